// ===== hdl/crc_pkg.sv =====
package crc_pkg;

    localparam int Z_W    = 22;
    localparam int V_W    = 16;
    localparam int R_W    = 24;
    localparam int G_W    = 21;
    localparam int B_W    = 20;
    localparam int CFG_W  = 21;
    localparam int IDX_W  = 1;
    localparam int CALC_W = 24;
    localparam int F_W    = 23;
    localparam int PROD_W = R_W + F_W;

    localparam logic [IDX_W-1:0] CFG_GAMMA = 1'd0;
    localparam logic [IDX_W-1:0] CFG_BETA  = 1'd1;

    // magnitudes
    typedef struct packed {
        logic [Z_W-1:0] a;
        logic [V_W-1:0] b;
        logic [R_W-1:0] r;
        logic           last;
    } t_s1;

    // branch outcome and operands for the random test
    typedef struct packed {
        logic           used;
        logic           known;
        logic           known_rej;
        logic [F_W-1:0] f;
        logic [F_W-1:0] gg;
        logic [R_W-1:0] r;
        logic           last;
    } t_s2;

    typedef struct packed {
        logic              used;
        logic              known;
        logic              known_rej;
        logic [PROD_W-1:0] prod;
        logic [F_W-1:0]    gg;
        logic              last;
    } t_s3;

endpackage

// ===== hdl/crc_magnitude.sv =====
module crc_magnitude (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [crc_pkg::Z_W-1:0]      i_z,
    input  logic signed [crc_pkg::V_W-1:0]      i_v,
    input  logic        [crc_pkg::R_W-1:0]      i_r,
    input  logic                                i_last,
    output crc_pkg::t_s1                        o_s1
);

    crc_pkg::t_s1 r_s1;
    crc_pkg::t_s1 n_s1;

    always_comb begin
        n_s1.a    = i_z[crc_pkg::Z_W-1] ? crc_pkg::Z_W'(-i_z) : crc_pkg::Z_W'(i_z);
        n_s1.b    = i_v[crc_pkg::V_W-1] ? crc_pkg::V_W'(-i_v) : crc_pkg::V_W'(i_v);
        n_s1.r    = i_r;
        n_s1.last = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

// ===== hdl/crc_branch.sv =====
module crc_branch (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [crc_pkg::G_W-1:0]     i_gamma,
    input  logic [crc_pkg::B_W-1:0]     i_beta,
    input  crc_pkg::t_s1                i_s1,
    output crc_pkg::t_s2                o_s2
);

    crc_pkg::t_s2 r_s2;
    crc_pkg::t_s2 n_s2;

    always_comb begin
        logic signed [crc_pkg::CALC_W-1:0] a_s;
        logic signed [crc_pkg::CALC_W-1:0] b_s;
        logic signed [crc_pkg::CALC_W-1:0] g_s;
        logic signed [crc_pkg::CALC_W-1:0] be_s;
        logic signed [crc_pkg::CALC_W-1:0] max_ab;
        logic signed [crc_pkg::CALC_W-1:0] diff;
        logic signed [crc_pkg::CALC_W-1:0] t1;
        logic signed [crc_pkg::CALC_W-1:0] t2;
        logic signed [crc_pkg::CALC_W-1:0] gh;
        logic signed [crc_pkg::CALC_W-1:0] f;
        logic signed [crc_pkg::CALC_W-1:0] gg;
        logic                              fast;
        logic                              over;
        logic                              low;
        logic                              bad;

        a_s  = signed'({{(crc_pkg::CALC_W-crc_pkg::Z_W){1'b0}}, i_s1.a});
        b_s  = signed'({{(crc_pkg::CALC_W-crc_pkg::V_W){1'b0}}, i_s1.b});
        g_s  = signed'({{(crc_pkg::CALC_W-crc_pkg::G_W){1'b0}}, i_gamma});
        be_s = signed'({{(crc_pkg::CALC_W-crc_pkg::B_W){1'b0}}, i_beta});

        fast = (a_s >= be_s) && ((a_s + be_s) < g_s);
        over = a_s >= g_s;
        low  = a_s < be_s;

        max_ab = (a_s > b_s) ? a_s : b_s;
        diff   = a_s - b_s;
        if (diff < 0) begin
            diff = -diff;
        end
        t1 = g_s - diff;
        if (t1 < 0) begin
            t1 = '0;
        end
        t2 = g_s - a_s - b_s;
        if (t2 < 0) begin
            t2 = '0;
        end
        // a >= beta on the high side, so max(a, beta) is a
        gh = g_s - a_s;
        if (gh < 0) begin
            gh = '0;
        end

        if (low) begin
            f  = (g_s <<< 1) - (max_ab <<< 1);
            gg = (g_s - be_s) <<< 1;
        end else begin
            f  = t1 + t2;
            gg = gh <<< 1;
        end

        // a negative F rejects, and so does a negative G since R*F >= 0
        bad = (f < 0) || (gg < 0);

        n_s2.used      = !fast && !over;
        n_s2.known     = fast || over || bad;
        n_s2.known_rej = over || (!fast && bad);
        n_s2.f         = crc_pkg::F_W'(f);
        n_s2.gg        = crc_pkg::F_W'(gg);
        n_s2.r         = i_s1.r;
        n_s2.last      = i_s1.last;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

// ===== hdl/crc_product.sv =====
module crc_product (
    input  logic            i_clk,
    input  logic            i_en,
    input  crc_pkg::t_s2    i_s2,
    output crc_pkg::t_s3    o_s3
);

    crc_pkg::t_s3 r_s3;
    crc_pkg::t_s3 n_s3;

    always_comb begin
        n_s3.used      = i_s2.used;
        n_s3.known     = i_s2.known;
        n_s3.known_rej = i_s2.known_rej;
        n_s3.prod      = crc_pkg::PROD_W'(i_s2.r) * crc_pkg::PROD_W'(i_s2.f);
        n_s3.gg        = i_s2.gg;
        n_s3.last      = i_s2.last;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3 <= n_s3;
        end
    end

    assign o_s3 = r_s3;

endmodule

// ===== hdl/coefficient_rejection_check.sv =====
// Rejection test for one signature coefficient per transaction. Each input
// transaction gives exactly one result, in order; a new coefficient is
// accepted in every cycle while the result side keeps up, through the
// five-stage pipeline (input register, magnitudes, branch selection, 24x23
// multiply, compare and sticky flag). random_used tells the feeder whether
// this coefficient consumed its random word. reject_so_far is the OR of
// rejections since the last transaction marked last, and with is_final set
// it is the polynomial verdict. The user must write gamma_bound and beta_margin
// only while the pipeline is empty; the block itself does not enforce it.
module coefficient_rejection_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [crc_pkg::Z_W-1:0]      i_z_coeff,
    input  logic signed [crc_pkg::V_W-1:0]      i_shift_coeff,
    input  logic        [crc_pkg::R_W-1:0]      i_random_word,
    input  logic                                i_last,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_random_used,
    output logic                                o_coeff_reject,
    output logic                                o_reject_so_far,
    output logic                                o_is_final,
    input  logic                                i_cfg_we,
    input  logic [crc_pkg::IDX_W-1:0]           i_cfg_index,
    input  logic [crc_pkg::CFG_W-1:0]           i_cfg_data
);

    logic [crc_pkg::G_W-1:0]            r_gamma;
    logic [crc_pkg::B_W-1:0]            r_beta;

    logic                               r_v0;
    logic                               r_v1;
    logic                               r_v2;
    logic                               r_v3;
    logic                               r_v4;
    logic signed [crc_pkg::Z_W-1:0]     r_z;
    logic signed [crc_pkg::V_W-1:0]     r_v;
    logic        [crc_pkg::R_W-1:0]     r_r;
    logic                               r_last;

    logic                               r_sticky;
    logic                               r_used;
    logic                               r_rej;
    logic                               r_so_far;
    logic                               r_final;

    logic                               w_rdy0;
    logic                               w_rdy1;
    logic                               w_rdy2;
    logic                               w_rdy3;
    logic                               w_rdy4;
    logic                               n_rej;
    logic                               n_so_far;

    crc_pkg::t_s1                       w_s1;
    crc_pkg::t_s2                       w_s2;
    crc_pkg::t_s3                       w_s3;

    // a stage loads when it is empty or its contents move on
    assign w_rdy4 = !r_v4 || !i_out_stall;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign w_rdy0 = !r_v0 || w_rdy1;
    assign o_in_stall = !w_rdy0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= crc_pkg::G_W'(131072);
            r_beta  <= crc_pkg::B_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                crc_pkg::CFG_GAMMA: r_gamma <= i_cfg_data[crc_pkg::G_W-1:0];
                crc_pkg::CFG_BETA:  r_beta  <= i_cfg_data[crc_pkg::B_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy0) r_v0 <= i_in_valid;
            if (w_rdy1) r_v1 <= r_v0;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy0) begin
            r_z    <= i_z_coeff;
            r_v    <= i_shift_coeff;
            r_r    <= i_random_word;
            r_last <= i_last;
        end
    end

    crc_magnitude u_magnitude (
        .i_clk  (i_clk),
        .i_en   (w_rdy1),
        .i_z    (r_z),
        .i_v    (r_v),
        .i_r    (r_r),
        .i_last (r_last),
        .o_s1   (w_s1)
    );

    crc_branch u_branch (
        .i_clk   (i_clk),
        .i_en    (w_rdy2),
        .i_gamma (r_gamma),
        .i_beta  (r_beta),
        .i_s1    (w_s1),
        .o_s2    (w_s2)
    );

    crc_product u_product (
        .i_clk (i_clk),
        .i_en  (w_rdy3),
        .i_s2  (w_s2),
        .o_s3  (w_s3)
    );

    // reject when R*F > G*2^24
    assign n_rej = w_s3.known ? w_s3.known_rej
                              : (w_s3.prod > {w_s3.gg, {crc_pkg::R_W{1'b0}}});
    assign n_so_far = r_sticky || n_rej;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sticky <= 1'b0;
        end else if (w_rdy4 && r_v3) begin
            r_sticky <= w_s3.last ? 1'b0 : n_so_far;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_used   <= w_s3.used;
            r_rej    <= n_rej;
            r_so_far <= n_so_far;
            r_final  <= w_s3.last;
        end
    end

    assign o_out_valid     = r_v4;
    assign o_random_used   = r_used;
    assign o_coeff_reject  = r_rej;
    assign o_reject_so_far = r_so_far;
    assign o_is_final      = r_final;

endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint WORD_SCALE  = 64'sd16777216;
    localparam longint A_MAX       = 64'sd2097152;
    localparam int     DRAIN_CYCLES = 12;
    localparam int     MAX_PRINTS  = 100;

    typedef struct packed {
        logic used;
        logic rej;
        logic so_far;
        logic is_last;
    } t_verdict;

    logic                             i_clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic signed [crc_pkg::Z_W-1:0]   z_coeff = '0;
    logic signed [crc_pkg::V_W-1:0]   shift_coeff = '0;
    logic        [crc_pkg::R_W-1:0]   random_word = '0;
    logic                             last_flag = 1'b0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic                             random_used;
    logic                             coeff_reject;
    logic                             reject_so_far;
    logic                             is_final;
    logic                             cfg_we = 1'b0;
    logic [crc_pkg::IDX_W-1:0]        cfg_index = '0;
    logic [crc_pkg::CFG_W-1:0]        cfg_data = '0;

    // local copy of the block's registers and sticky flag
    logic [crc_pkg::G_W-1:0] gamma1 = 21'd131072;
    logic [crc_pkg::B_W-1:0] beta2 = 20'd1;
    logic                    poly_rejected = 1'b0;

    t_verdict pending_verdicts[$];
    int       mismatches = 0;
    int       results_seen = 0;
    int       gap_max = 0;
    int       burst_left = 0;
    int       stall_level = 0;
    int       stall_run = 0;

    coefficient_rejection_check uut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_z_coeff       (z_coeff),
        .i_shift_coeff   (shift_coeff),
        .i_random_word   (random_word),
        .i_last          (last_flag),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_random_used   (random_used),
        .o_coeff_reject  (coeff_reject),
        .o_reject_so_far (reject_so_far),
        .o_is_final      (is_final),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // F and G of the random test, low part when a is below the margin
    function automatic void branch_terms(input longint a, input longint b, input longint g,
                                         input longint be, output longint f,
                                         output longint gg);
        longint hi, d, s, m;
        if (a < be) begin
            hi = (a > b) ? a : b;
            f = 2 * g - 2 * hi;
            gg = 2 * (g - be);
        end else begin
            d = (a > b) ? a - b : b - a;
            d = g - d;
            s = g - (a + b);
            f = ((d > 0) ? d : 0) + ((s > 0) ? s : 0);
            m = g - ((a > be) ? a : be);
            gg = 2 * ((m > 0) ? m : 0);
        end
    endfunction

    function automatic t_verdict predict_verdict(logic signed [crc_pkg::Z_W-1:0] z,
                                                 logic signed [crc_pkg::V_W-1:0] v,
                                                 logic [crc_pkg::R_W-1:0] r,
                                                 logic is_last);
        longint a, b, g, be, f, gg, rw;
        t_verdict res;
        a = z;
        b = v;
        if (a < 0) a = -a;
        if (b < 0) b = -b;
        g = gamma1;
        be = beta2;
        rw = r;
        res = '0;
        res.is_last = is_last;
        if (!(a >= be && a < g - be)) begin
            if (a >= g) begin
                res.rej = 1'b1;
            end else begin
                res.used = 1'b1;
                branch_terms(a, b, g, be, f, gg);
                res.rej = (f < 0) || (rw * f > gg * WORD_SCALE);
            end
        end
        res.so_far = poly_rejected | res.rej;
        poly_rejected = is_last ? 1'b0 : res.so_far;
        return res;
    endfunction

    // random word right at (above = 0) or just past (above = 1) the reject threshold
    function automatic logic [crc_pkg::R_W-1:0] threshold_word(longint a, longint b,
                                                                bit above);
        longint f, gg, t;
        branch_terms(a, b, gamma1, beta2, f, gg);
        if (f <= 0 || gg < 0) return crc_pkg::R_W'($urandom);
        t = gg * WORD_SCALE / f + above;
        if (t > 64'sd16777215) t = 64'sd16777215;
        return t[crc_pkg::R_W-1:0];
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic idle_input(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic send_coeff(logic signed [crc_pkg::Z_W-1:0] z,
                              logic signed [crc_pkg::V_W-1:0] v,
                              logic [crc_pkg::R_W-1:0] r, logic is_last);
        if (burst_left == 0) begin
            if (gap_max > 0) idle_input($urandom_range(1, gap_max));
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        in_valid <= 1'b1;
        z_coeff <= z;
        shift_coeff <= v;
        random_word <= r;
        last_flag <= is_last;
        do @(posedge i_clk); while (in_stall);
        pending_verdicts.push_back(predict_verdict(z, v, r, is_last));
    endtask

    task automatic drain_pipeline();
        idle_input(1);
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(logic [crc_pkg::IDX_W-1:0] idx,
                                logic [crc_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == crc_pkg::CFG_GAMMA) gamma1 = data[crc_pkg::G_W-1:0];
        else beta2 = data[crc_pkg::B_W-1:0];
    endtask

    task automatic apply_setting(logic [crc_pkg::CFG_W-1:0] g, logic [crc_pkg::CFG_W-1:0] be);
        drain_pipeline();
        write_config(crc_pkg::CFG_GAMMA, g);
        write_config(crc_pkg::CFG_BETA, be);
    endtask

    // after reset: both windows, outright reject, sticky carry and clear
    task automatic test_reset_values();
        gap_max = 0;
        stall_level = 1;
        send_coeff(22'sd0, 16'sd0, 24'd0, 1'b0);
        send_coeff(22'sd0, 16'sd32767, 24'hFFFFFF, 1'b0);
        send_coeff(22'sd1, -16'sd32768, 24'h555555, 1'b0);
        send_coeff(-22'sd131070, 16'sd1, 24'hAAAAAA, 1'b0);
        send_coeff(22'sd131071, 16'sd0, 24'hFFFFFF, 1'b0);
        send_coeff(22'sd131072, -16'sd1, 24'd0, 1'b1);
        send_coeff(22'sd5, 16'sd5, 24'h123456, 1'b1);
        send_coeff(22'sd131071, 16'sd50, threshold_word(131071, 50, 1'b0), 1'b0);
        send_coeff(-22'sd131071, -16'sd50, threshold_word(131071, 50, 1'b1), 1'b1);
        send_coeff(22'sd2097151, -16'sd1, 24'd1, 1'b0);
        send_coeff(-22'sd2097152, 16'sd0, 24'hFFFFFF, 1'b1);
    endtask

    // zero bound, margin above bound, empty accept window, widest registers
    task automatic test_bound_extremes();
        gap_max = 3;
        stall_level = 2;
        apply_setting(21'd0, 21'd0);
        send_coeff(22'sd0, 16'sd0, 24'd0, 1'b0);
        send_coeff(-22'sd1, 16'sd3, 24'hFFFFFF, 1'b1);
        apply_setting(21'd1, 21'd0);
        send_coeff(22'sd0, 16'sd0, 24'hFFFFFF, 1'b0);
        send_coeff(22'sd1, 16'sd0, 24'd0, 1'b1);
        apply_setting(21'd100, 21'd300);
        send_coeff(22'sd0, 16'sd0, 24'd0, 1'b1);
        send_coeff(22'sd50, 16'sd32767, 24'd7, 1'b1);
        apply_setting(21'd1000, 21'd600);
        send_coeff(22'sd600, 16'sd10, 24'h800000, 1'b0);
        send_coeff(-22'sd599, 16'sd700, 24'h000100, 1'b1);
        apply_setting(21'd2097151, 21'd1048575);
        send_coeff(22'sd2097151, 16'sd0, 24'd0, 1'b0);
        send_coeff(-22'sd2097152, 16'sd0, 24'd0, 1'b0);
        send_coeff(22'sd1048575, -16'sd32768, 24'hFFFFFF, 1'b1);
        apply_setting(21'd1048576, 21'd1048575);
        send_coeff(22'sd1048575, 16'sd1, 24'hFFFFFF, 1'b0);
        send_coeff(22'sd0, 16'sd32767, 24'd1, 1'b1);
    endtask

    task automatic run_random_items(int count);
        longint a, b, g, be, lo;
        logic signed [crc_pkg::Z_W-1:0] z;
        logic signed [crc_pkg::V_W-1:0] v;
        logic [crc_pkg::R_W-1:0] r;
        logic is_last;
        for (int i = 0; i < count; i++) begin
            g = gamma1;
            be = beta2;
            case ($urandom_range(0, 7))
                0: a = (be > 0) ? $urandom_range(be - 1) : 0;
                1: a = (g - be > be) ? be + $urandom_range(g - be - 1 - be) : $urandom_range(g);
                2: begin
                    lo = (g - be > 0) ? g - be : 0;
                    a = (g > lo) ? lo + $urandom_range(g - 1 - lo) : g;
                end
                3: a = g + $urandom_range(A_MAX - g);
                4: begin
                    case ($urandom_range(0, 6))
                        0: a = be - 1;
                        1: a = be;
                        2: a = g - be - 1;
                        3: a = g - be;
                        4: a = g - 1;
                        5: a = g;
                        default: a = g + 1;
                    endcase
                    if (a < 0) a = 0;
                end
                default: begin
                    z = crc_pkg::Z_W'($urandom);
                    a = z;
                    if (a < 0) a = -a;
                end
            endcase
            if (a >= A_MAX) a = A_MAX;
            if (a == A_MAX || $urandom_range(0, 1)) z = crc_pkg::Z_W'(-a);
            else z = crc_pkg::Z_W'(a);

            case ($urandom_range(0, 3))
                2: begin
                    b = a + $urandom_range(0, 8) - 4;
                    if (b < 0) b = 0;
                    if (b > 32767) b = 32767;
                    v = $urandom_range(0, 1) ? crc_pkg::V_W'(-b) : crc_pkg::V_W'(b);
                end
                3: begin
                    case ($urandom_range(0, 3))
                        0: v = -16'sd32768;
                        1: v = 16'sd32767;
                        2: v = 16'sd0;
                        default: v = -16'sd1;
                    endcase
                end
                default: v = crc_pkg::V_W'($urandom);
            endcase
            b = v;
            if (b < 0) b = -b;

            if ($urandom_range(0, 1)) r = threshold_word(a, b, $urandom_range(0, 1));
            else if ($urandom_range(0, 3) == 0) r = $urandom_range(0, 1) ? '1 : '0;
            else r = crc_pkg::R_W'($urandom);
            is_last = ($urandom_range(0, 9) == 0);
            send_coeff(z, v, r, is_last);
        end
    endtask

    task automatic test_random_settings();
        logic [crc_pkg::CFG_W-1:0] g, be;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin g = 21'd131072; be = 21'd1; end
                1: begin g = 21'd1; be = 21'd0; end
                2: begin
                    g = crc_pkg::CFG_W'($urandom_range(1, 64));
                    be = crc_pkg::CFG_W'($urandom_range(0, g));
                end
                3: begin
                    g = crc_pkg::CFG_W'($urandom_range(1, 1048576));
                    be = crc_pkg::CFG_W'($urandom_range(0, g / 4));
                end
                4: begin g = 21'd2097151; be = 21'd1048575; end
                5: begin
                    g = crc_pkg::CFG_W'($urandom_range(1000, 100000));
                    be = g + crc_pkg::CFG_W'($urandom_range(1, 5000));
                end
                // raw beta data: bit 20 is dropped by the register
                6: begin
                    g = crc_pkg::CFG_W'($urandom_range(1, 2097151));
                    be = crc_pkg::CFG_W'($urandom);
                end
                default: begin g = 21'd1048576; be = 21'd1048575; end
            endcase
            gap_max = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 4 : 12;
            stall_level = ph % 4;
            apply_setting(g, be);
            run_random_items(210);
        end
    endtask

    // receiver: stall runs of random length, density set per test
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            out_stall <= (stall_level != 0) && ($urandom_range(0, 3) < stall_level);
            stall_run <= $urandom_range(1, 8);
        end else begin
            stall_run <= stall_run - 1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_verdict want;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            results_seen++;
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("result %0d with no transaction pending",
                                          results_seen));
            end else begin
                want = pending_verdicts.pop_front();
                if (random_used !== want.used)
                    report_mismatch($sformatf("result %0d random_used %b, want %b",
                                              results_seen, random_used, want.used));
                if (coeff_reject !== want.rej)
                    report_mismatch($sformatf("result %0d coeff_reject %b, want %b",
                                              results_seen, coeff_reject, want.rej));
                if (reject_so_far !== want.so_far)
                    report_mismatch($sformatf("result %0d reject_so_far %b, want %b",
                                              results_seen, reject_so_far, want.so_far));
                if (is_final !== want.is_last)
                    report_mismatch($sformatf("result %0d is_final %b, want %b",
                                              results_seen, is_final, want.is_last));
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;
        test_reset_values();
        test_bound_extremes();
        test_random_settings();
        drain_pipeline();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
